@@ rtl/core/two_axis_stepper_ramp_generator_macros.svh @@
// Assertion macros shared by the stepper ramp generator modules.
// No dependencies; included by the files that carry checks.
`ifndef TWO_AXIS_STEPPER_RAMP_GENERATOR_MACROS_SVH
`define TWO_AXIS_STEPPER_RAMP_GENERATOR_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define TSRG_CHECK(label, clk_s, rst_s, cond, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define TSRG_IMPLY(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define TSRG_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/tsrg_pkg.sv @@
// Shared types and constants of the two-axis stepper ramp generator.
// No dependencies; imported by every module of the block.
package tsrg_pkg;

  // Default parameter values.
  localparam int POS_BITS_DEF        = 20;
  localparam int X_START_HOLD_MS_DEF = 80;
  localparam int Z_START_HOLD_MS_DEF = 100;

  // Fixed field widths.
  localparam int PERIOD_W = 16;
  localparam int SLOW_W   = 21;
  localparam int TIMER_W  = 16;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 5;

  // Register reset values.
  localparam logic [PERIOD_W-1:0] START_PERIOD_RST = 16'd40;
  localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST  = 16'd10;
  localparam logic [SLOW_W-1:0]   SLOW_EDGES_RST   = 21'd2000;
  localparam logic [TIMER_W-1:0]  CHANGE_MS_RST    = 16'd1;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_MOVE = 2'd1,
    REQ_HOME = 2'd2
  } req_t;

  // Register indexes on the configuration port (word address).
  typedef enum logic [2:0] {
    CFG_X_START_PERIOD = 3'd0,
    CFG_X_FAST_PERIOD  = 3'd1,
    CFG_Z_START_PERIOD = 3'd2,
    CFG_Z_FAST_PERIOD  = 3'd3,
    CFG_X_SLOW_EDGES   = 3'd4,
    CFG_Z_SLOW_EDGES   = 3'd5,
    CFG_Z_CHANGE_MS    = 3'd6
  } cfg_idx_t;

  // Speed phases of one axis.
  typedef enum logic [4:0] {
    PH_START    = 5'b00001,
    PH_ACCEL    = 5'b00010,
    PH_FAST     = 5'b00100,
    PH_SLOWDOWN = 5'b01000,
    PH_SLOW     = 5'b10000
  } phase_t;

  // Configuration register set.
  typedef struct packed {
    logic [PERIOD_W-1:0] x_start_period;
    logic [PERIOD_W-1:0] x_fast_period;
    logic [PERIOD_W-1:0] z_start_period;
    logic [PERIOD_W-1:0] z_fast_period;
    logic [SLOW_W-1:0]   x_slow_edges;
    logic [SLOW_W-1:0]   z_slow_edges;
    logic [TIMER_W-1:0]  z_change_ms;
  } cfg_t;

  // Qualified request controls sent to both axes.
  typedef struct packed {
    logic move;
    logic home;
    logic tick;
    logic ms;
  } axis_ctl_t;

  // Status returned by one axis.
  typedef struct packed {
    logic busy;
    logic busy_next;
    logic pulse_next;
    logic dir_next;
  } axis_stat_t;

endpackage

@@ rtl/core/two_axis_stepper_ramp_generator.sv @@
// Top level of the two-axis stepper ramp generator.
// Depends on tsrg_pkg, tsrg_cfg, tsrg_axis and the assertion macro header.
//
// Usage:
//  - Requests enter on in_valid/in_stall with req_type, target_x, target_z
//    and ms_tick. A tick advances both axes by one loop pass, a move arms
//    both axes toward an absolute target, a home zeroes the stored position.
//  - Every request gives exactly one result on out_valid/out_stall: step
//    levels, directions, busy_res, move_done and rejected.
//  - A request passes through the input register, then the axis update
//    and the result register. Throughput is one request per cycle while
//    the receiver does not stall; it is set by the update of the axis
//    state, which every request reads and writes.
//  - When the receiver stalls, the finished result waits in the result
//    register and one more request is taken into the input register; after
//    that in_stall rises until the result is taken.
//  - Registers must be written on the APB-style port only with no request
//    in flight, which the block does not enforce. Reset clears position,
//    counters, sets step levels high, directions low, registers to defaults.
`include "two_axis_stepper_ramp_generator_macros.svh"
module two_axis_stepper_ramp_generator import tsrg_pkg::*; #(
  parameter int POS_BITS        = POS_BITS_DEF,
  parameter int X_START_HOLD_MS = X_START_HOLD_MS_DEF,
  parameter int Z_START_HOLD_MS = Z_START_HOLD_MS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // Request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type,
  input  logic [POS_BITS-1:0] target_x,
  input  logic [POS_BITS-1:0] target_z,
  input  logic                ms_tick,
  // Result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                x_pulse,
  output logic                z_pulse,
  output logic                x_dir,
  output logic                z_dir,
  output logic                busy_res,
  output logic                move_done,
  output logic                rejected,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  cfg_t cfg;

  // Input register.
  logic                r_valid;
  logic [1:0]          r_req;
  logic [POS_BITS-1:0] r_tx;
  logic [POS_BITS-1:0] r_tz;
  logic                r_ms;

  logic       can_out, fire, in_acc, busy, busy_after, is_mod, rej, done;
  axis_ctl_t  ctl;
  axis_stat_t x_st, z_st;

  tsrg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: a held request moves on when the result register is free.
  assign can_out  = !out_valid || !out_stall;
  assign fire     = r_valid && can_out;
  assign in_stall = r_valid && !can_out;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (in_acc) begin
      r_valid <= 1'b1;
    end else if (fire) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      r_req <= req_type;
      r_tx  <= target_x;
      r_tz  <= target_z;
      r_ms  <= ms_tick;
    end
  end

  // Request decode against the current busy state.
  assign busy   = x_st.busy || z_st.busy;
  assign is_mod = (r_req == REQ_MOVE) || (r_req == REQ_HOME);

  always_comb begin
    ctl.move = fire && !busy && (r_req == REQ_MOVE);
    ctl.home = fire && !busy && (r_req == REQ_HOME);
    ctl.tick = fire && busy && (r_req == REQ_TICK);
    ctl.ms   = r_ms;
  end

  assign rej        = fire && busy && is_mod;
  assign busy_after = x_st.busy_next || z_st.busy_next;
  assign done       = ctl.tick && !busy_after;

  tsrg_axis #(
    .POS_BITS (POS_BITS),
    .HOLD_MS  (X_START_HOLD_MS),
    .ZAXIS    (1'b0)
  ) u_x (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .all_idle_next (!busy_after),
    .target        (r_tx),
    .start_period  (cfg.x_start_period),
    .fast_period   (cfg.x_fast_period),
    .slow_edges    (cfg.x_slow_edges),
    .change_ms     (cfg.z_change_ms),
    .stat          (x_st)
  );

  tsrg_axis #(
    .POS_BITS (POS_BITS),
    .HOLD_MS  (Z_START_HOLD_MS),
    .ZAXIS    (1'b1)
  ) u_z (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .all_idle_next (!busy_after),
    .target        (r_tz),
    .start_period  (cfg.z_start_period),
    .fast_period   (cfg.z_fast_period),
    .slow_edges    (cfg.z_slow_edges),
    .change_ms     (cfg.z_change_ms),
    .stat          (z_st)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      x_pulse   <= x_st.pulse_next;
      z_pulse   <= z_st.pulse_next;
      x_dir     <= x_st.dir_next;
      z_dir     <= z_st.dir_next;
      busy_res  <= busy_after;
      move_done <= done;
      rejected  <= rej;
    end
  end

  // Checks.
  `TSRG_NEXT(a_fire_loads, clk, rst, fire, out_valid, "processed request produced no result")
  `TSRG_IMPLY(a_done_idle, clk, rst, out_valid && move_done, !busy_res && x_pulse && z_pulse, "move end with axis still active")
  `TSRG_IMPLY(a_done_rej, clk, rst, out_valid, !(move_done && rejected), "result both done and rejected")

endmodule

@@ rtl/core/tsrg_cfg.sv @@
// Configuration register file on an APB-style port.
// Depends on tsrg_pkg.
module tsrg_cfg import tsrg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr_en;
  cfg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = cfg_idx_t'(paddr[ADDR_W-1:2]);

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_start_period <= START_PERIOD_RST;
      cfg.x_fast_period  <= FAST_PERIOD_RST;
      cfg.z_start_period <= START_PERIOD_RST;
      cfg.z_fast_period  <= FAST_PERIOD_RST;
      cfg.x_slow_edges   <= SLOW_EDGES_RST;
      cfg.z_slow_edges   <= SLOW_EDGES_RST;
      cfg.z_change_ms    <= CHANGE_MS_RST;
    end else if (wr_en) begin
      case (idx)
        CFG_X_START_PERIOD: cfg.x_start_period <= pwdata[PERIOD_W-1:0];
        CFG_X_FAST_PERIOD:  cfg.x_fast_period  <= pwdata[PERIOD_W-1:0];
        CFG_Z_START_PERIOD: cfg.z_start_period <= pwdata[PERIOD_W-1:0];
        CFG_Z_FAST_PERIOD:  cfg.z_fast_period  <= pwdata[PERIOD_W-1:0];
        CFG_X_SLOW_EDGES:   cfg.x_slow_edges   <= pwdata[SLOW_W-1:0];
        CFG_Z_SLOW_EDGES:   cfg.z_slow_edges   <= pwdata[SLOW_W-1:0];
        CFG_Z_CHANGE_MS:    cfg.z_change_ms    <= pwdata[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (idx)
      CFG_X_START_PERIOD: prdata = DATA_W'(cfg.x_start_period);
      CFG_X_FAST_PERIOD:  prdata = DATA_W'(cfg.x_fast_period);
      CFG_Z_START_PERIOD: prdata = DATA_W'(cfg.z_start_period);
      CFG_Z_FAST_PERIOD:  prdata = DATA_W'(cfg.z_fast_period);
      CFG_X_SLOW_EDGES:   prdata = DATA_W'(cfg.x_slow_edges);
      CFG_Z_SLOW_EDGES:   prdata = DATA_W'(cfg.z_slow_edges);
      CFG_Z_CHANGE_MS:    prdata = DATA_W'(cfg.z_change_ms);
      default:            prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/tsrg_axis.sv @@
// One stepper axis: position, edge counters, period divider and speed ramp.
// Depends on tsrg_pkg and the assertion macro header.
`include "two_axis_stepper_ramp_generator_macros.svh"
module tsrg_axis import tsrg_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF,
  parameter int HOLD_MS  = X_START_HOLD_MS_DEF,
  parameter bit ZAXIS    = 1'b0
) (
  input  logic                clk,
  input  logic                rst,
  input  axis_ctl_t           ctl,
  input  logic                all_idle_next,
  input  logic [POS_BITS-1:0] target,
  input  logic [PERIOD_W-1:0] start_period,
  input  logic [PERIOD_W-1:0] fast_period,
  input  logic [SLOW_W-1:0]   slow_edges,
  input  logic [TIMER_W-1:0]  change_ms,
  output axis_stat_t          stat
);

  localparam int EW = POS_BITS + 1;
  localparam int CW = (EW > SLOW_W) ? EW : SLOW_W;
  localparam logic [TIMER_W-1:0]  HOLD = TIMER_W'(HOLD_MS);
  localparam logic [PERIOD_W:0]   STEP = ZAXIS ? (PERIOD_W+1)'(1) : (PERIOD_W+1)'(2);
  localparam logic [TIMER_W-1:0]  TIMER_MAX = '1;

  // Architectural state.
  logic [POS_BITS-1:0] pos, pos_next;
  logic [EW-1:0]       edges_done, edges_done_next;
  logic [EW-1:0]       edges_total, edges_total_next;
  logic [EW-1:0]       slow_point, slow_point_next;
  logic [PERIOD_W-1:0] period, period_next;
  logic [PERIOD_W-1:0] divider, divider_next;
  logic [TIMER_W-1:0]  ms_timer, ms_timer_next;
  phase_t              phase, phase_next;
  logic                pulse, pulse_next;
  logic                dir, dir_next;

  // Helpers for a move request.
  logic                tgt_above;
  logic [POS_BITS-1:0] span;
  logic [EW-1:0]       total_new;
  logic [CW-1:0]       total_c, slow_c;
  logic [EW-1:0]       sp_new;

  // Helpers for a tick.
  logic                edge_hit;
  logic [TIMER_W-1:0]  timer_inc;
  logic                gate;

  assign tgt_above = target > pos;
  assign span      = tgt_above ? (target - pos) : (pos - target);
  assign total_new = {span, 1'b0};
  assign total_c   = CW'(total_new);
  assign slow_c    = CW'(slow_edges);
  assign sp_new    = (total_c > slow_c) ? EW'(total_c - slow_c) : (total_new >> 1);

  assign edge_hit  = (divider >= period) && (edges_done < edges_total);
  assign timer_inc = (ctl.ms && (ms_timer != TIMER_MAX)) ? ms_timer + 1'b1 : ms_timer;
  // X changes its period on every ramp call, Z only once the change time passed.
  assign gate      = ZAXIS ? (timer_inc >= change_ms) : 1'b1;

  // Next-state logic for one request.
  always_comb begin
    pos_next         = pos;
    edges_done_next  = edges_done;
    edges_total_next = edges_total;
    slow_point_next  = slow_point;
    period_next      = period;
    divider_next     = divider;
    ms_timer_next    = ms_timer;
    phase_next       = phase;
    dir_next         = dir;
    if (ctl.move) begin
      pos_next         = target;
      dir_next         = tgt_above;
      edges_total_next = total_new;
      slow_point_next  = sp_new;
      edges_done_next  = '0;
      period_next      = start_period;
      divider_next     = '0;
      ms_timer_next    = '0;
      phase_next       = PH_START;
    end else if (ctl.home) begin
      pos_next = '0;
    end else if (ctl.tick) begin
      ms_timer_next = timer_inc;
      if (edge_hit) begin
        divider_next    = '0;
        edges_done_next = edges_done + 1'b1;
        // Ramp step whenever the new edge count is even.
        if (!edges_done_next[0]) begin
          case (phase)
            PH_START: begin
              period_next = start_period;
              if (timer_inc >= HOLD) begin
                ms_timer_next = '0;
                phase_next    = PH_ACCEL;
              end
            end
            PH_ACCEL: begin
              if (gate) begin
                ms_timer_next = '0;
                if ({1'b0, period} <= {1'b0, fast_period} + STEP) begin
                  period_next = fast_period;
                  phase_next  = PH_FAST;
                end else begin
                  period_next = period - STEP[PERIOD_W-1:0];
                end
              end
            end
            PH_SLOWDOWN: begin
              if (gate) begin
                ms_timer_next = '0;
                if ({1'b0, period} + 1'b1 >= {1'b0, start_period}) begin
                  period_next = start_period;
                  phase_next  = PH_SLOW;
                end else begin
                  period_next = period + 1'b1;
                end
              end
            end
            default: ;
          endcase
          // Enter slowdown once past the slow point.
          if ((edges_done_next > slow_point) &&
              ((phase_next == PH_START) || (phase_next == PH_ACCEL) ||
               (phase_next == PH_FAST))) begin
            phase_next = PH_SLOWDOWN;
          end
        end
      end else begin
        divider_next = divider + 1'b1;
      end
    end
  end

  // Step level: toggles per edge, returns high on a move and at move end.
  always_comb begin
    pulse_next = pulse;
    if (ctl.move) begin
      pulse_next = 1'b1;
    end else if (ctl.tick) begin
      pulse_next = all_idle_next ? 1'b1 : (pulse ^ edge_hit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      edges_done  <= '0;
      edges_total <= '0;
      slow_point  <= '0;
      period      <= '0;
      divider     <= '0;
      ms_timer    <= '0;
      phase       <= PH_START;
      pulse       <= 1'b1;
      dir         <= 1'b0;
    end else begin
      pos         <= pos_next;
      edges_done  <= edges_done_next;
      edges_total <= edges_total_next;
      slow_point  <= slow_point_next;
      period      <= period_next;
      divider     <= divider_next;
      ms_timer    <= ms_timer_next;
      phase       <= phase_next;
      pulse       <= pulse_next;
      dir         <= dir_next;
    end
  end

  assign stat.busy       = edges_done < edges_total;
  assign stat.busy_next  = edges_done_next < edges_total_next;
  assign stat.pulse_next = pulse_next;
  assign stat.dir_next   = dir_next;

  // Checks.
  `TSRG_CHECK(a_done_le_total, clk, rst, edges_done <= edges_total, "edge count overran total")
  `TSRG_NEXT(a_move_clears, clk, rst, ctl.move, (edges_done == '0) && pulse, "move did not rearm axis")

endmodule

@@ tb/stepper_ramp_checker.sv @@
// Result checker for the two-axis stepper ramp generator: mirrors the
// register file, predicts every result from the accepted requests and compares.
// Depends on tsrg_pkg for widths, request codes, register indexes and phases.
`timescale 1ns / 100ps
module stepper_ramp_checker import tsrg_pkg::*; #(
  parameter int POS_W = POS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [POS_W-1:0]  target_x,
  input  logic [POS_W-1:0]  target_z,
  input  logic              ms_tick,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              x_pulse,
  input  logic              z_pulse,
  input  logic              x_dir,
  input  logic              z_dir,
  input  logic              busy_res,
  input  logic              move_done,
  input  logic              rejected,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output bit                motion_armed,
  output int                status_backlog,
  output int                error_count,
  output int                checked_count,
  output int                done_count,
  output int                reject_count
);

  // One result of the block.
  typedef struct packed {
    logic x_pulse;
    logic z_pulse;
    logic x_dir;
    logic z_dir;
    logic busy;
    logic move_done;
    logic rejected;
  } step_status_t;

  // Motion state of one axis.
  typedef struct packed {
    logic [SLOW_W-1:0]   done;
    logic [SLOW_W-1:0]   total;
    logic [SLOW_W-1:0]   slow_point;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] divider;
    phase_t              phase;
    logic [TIMER_W-1:0]  timer;
  } axis_t;

  cfg_t             regs;
  logic [POS_W-1:0] stored_x, stored_z;
  axis_t            x_axis, z_axis;
  logic             x_level, z_level, x_up, z_up;
  step_status_t     expected_status[$];

  function automatic bit axes_moving();
    return (x_axis.done < x_axis.total) || (z_axis.done < z_axis.total);
  endfunction

  // Load an axis for a new move of the given step distance.
  function automatic void arm_axis(inout axis_t a, input logic [POS_W-1:0] span,
                                   input logic [SLOW_W-1:0] slow_edges,
                                   input logic [PERIOD_W-1:0] start_p);
    a.total = SLOW_W'(span) << 1;
    a.slow_point = (a.total > slow_edges) ? a.total - slow_edges : a.total >> 1;
    a.done = '0;
    a.period = start_p;
    a.divider = '0;
    a.phase = PH_START;
    a.timer = '0;
  endfunction

  // Speed update whenever the edge count turns even: X steps its period by two when
  // speeding up, Z by one; both add one to slow down, Z only after the change interval.
  function automatic void ramp_axis(inout axis_t a, input bit z_rule,
                                    input logic [PERIOD_W-1:0] start_p, fast_p,
                                    input logic [TIMER_W-1:0] change_ms,
                                    input int hold_ms);
    int step;
    step = z_rule ? 1 : 2;
    case (a.phase)
      PH_START: begin
        a.period = start_p;
        if (int'(a.timer) >= hold_ms) begin
          a.timer = '0;
          a.phase = PH_ACCEL;
        end
      end
      PH_ACCEL: begin
        if (!z_rule || a.timer >= change_ms) begin
          a.timer = '0;
          if (int'(a.period) <= int'(fast_p) + step) begin
            a.period = fast_p;
            a.phase = PH_FAST;
          end else begin
            a.period = a.period - PERIOD_W'(step);
          end
        end
      end
      PH_SLOWDOWN: begin
        if (!z_rule || a.timer >= change_ms) begin
          a.timer = '0;
          if (int'(a.period) + 1 >= int'(start_p)) begin
            a.period = start_p;
            a.phase = PH_SLOW;
          end else begin
            a.period = a.period + 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (a.done > a.slow_point && a.phase inside {PH_START, PH_ACCEL, PH_FAST}) begin
      a.phase = PH_SLOWDOWN;
    end
  endfunction

  // One tick of an axis divider; returns 1 when a step edge comes out.
  function automatic bit advance_axis(inout axis_t a, input bit z_rule,
                                      input logic [PERIOD_W-1:0] start_p, fast_p,
                                      input logic [TIMER_W-1:0] change_ms,
                                      input int hold_ms);
    bit fired;
    fired = 1'b0;
    if (a.divider >= a.period && a.done < a.total) begin
      a.divider = '0;
      a.done = a.done + 1'b1;
      fired = 1'b1;
      if (!a.done[0]) begin
        ramp_axis(a, z_rule, start_p, fast_p, change_ms, hold_ms);
      end
    end else begin
      a.divider = a.divider + 1'b1;
    end
    return fired;
  endfunction

  // Apply one request to the predicted state and return the result it gives.
  function automatic step_status_t apply_request(input logic [1:0] kind,
                                                 input logic [POS_W-1:0] tx, tz,
                                                 input logic ms);
    step_status_t r;
    bit was_moving;
    logic [POS_W-1:0] dx, dz;
    was_moving = axes_moving();
    r = '0;
    if (kind == REQ_MOVE || kind == REQ_HOME) begin
      if (was_moving) begin
        r.rejected = 1'b1;
      end else if (kind == REQ_HOME) begin
        stored_x = '0;
        stored_z = '0;
      end else begin
        x_up = tx > stored_x;
        z_up = tz > stored_z;
        dx = x_up ? tx - stored_x : stored_x - tx;
        dz = z_up ? tz - stored_z : stored_z - tz;
        stored_x = tx;
        stored_z = tz;
        arm_axis(x_axis, dx, regs.x_slow_edges, regs.x_start_period);
        arm_axis(z_axis, dz, regs.z_slow_edges, regs.z_start_period);
        x_level = 1'b1;
        z_level = 1'b1;
      end
    end else if (kind == REQ_TICK && was_moving) begin
      if (ms) begin
        if (x_axis.timer != '1) x_axis.timer = x_axis.timer + 1'b1;
        if (z_axis.timer != '1) z_axis.timer = z_axis.timer + 1'b1;
      end
      if (advance_axis(x_axis, 1'b0, regs.x_start_period, regs.x_fast_period,
                       regs.z_change_ms, X_START_HOLD_MS_DEF)) begin
        x_level = ~x_level;
      end
      if (advance_axis(z_axis, 1'b1, regs.z_start_period, regs.z_fast_period,
                       regs.z_change_ms, Z_START_HOLD_MS_DEF)) begin
        z_level = ~z_level;
      end
      if (!axes_moving()) begin
        r.move_done = 1'b1;
        x_level = 1'b1;
        z_level = 1'b1;
      end
    end
    r.x_pulse = x_level;
    r.z_pulse = z_level;
    r.x_dir = x_up;
    r.z_dir = z_up;
    r.busy = axes_moving();
    return r;
  endfunction

  task automatic check_field(input string name, input logic want, input logic seen);
    if (seen !== want) begin
      $display("%0t ns: %s expected %0b, actual %0b", $time, name, want, seen);
      error_count++;
    end
  endtask

  // Register writes, result comparison and request prediction, in that order
  // so that a result is never matched against a request taken in the same cycle.
  always @(posedge clk) begin : watch
    step_status_t seen;
    step_status_t want;
    if (rst) begin
      regs.x_start_period = START_PERIOD_RST;
      regs.x_fast_period  = FAST_PERIOD_RST;
      regs.z_start_period = START_PERIOD_RST;
      regs.z_fast_period  = FAST_PERIOD_RST;
      regs.x_slow_edges   = SLOW_EDGES_RST;
      regs.z_slow_edges   = SLOW_EDGES_RST;
      regs.z_change_ms    = CHANGE_MS_RST;
      stored_x = '0;
      stored_z = '0;
      x_axis = '0;
      x_axis.phase = PH_START;
      z_axis = '0;
      z_axis.phase = PH_START;
      x_level = 1'b1;
      z_level = 1'b1;
      x_up = 1'b0;
      z_up = 1'b0;
      expected_status.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_idx_t'(paddr[ADDR_W-1:2]))
          CFG_X_START_PERIOD: regs.x_start_period = pwdata[PERIOD_W-1:0];
          CFG_X_FAST_PERIOD:  regs.x_fast_period  = pwdata[PERIOD_W-1:0];
          CFG_Z_START_PERIOD: regs.z_start_period = pwdata[PERIOD_W-1:0];
          CFG_Z_FAST_PERIOD:  regs.z_fast_period  = pwdata[PERIOD_W-1:0];
          CFG_X_SLOW_EDGES:   regs.x_slow_edges   = pwdata[SLOW_W-1:0];
          CFG_Z_SLOW_EDGES:   regs.z_slow_edges   = pwdata[SLOW_W-1:0];
          CFG_Z_CHANGE_MS:    regs.z_change_ms    = pwdata[TIMER_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        seen = {x_pulse, z_pulse, x_dir, z_dir, busy_res, move_done, rejected};
        if (expected_status.size() == 0) begin
          $display("%0t ns: result with no request outstanding, actual %b", $time, seen);
          error_count++;
        end else begin
          want = expected_status.pop_front();
          checked_count++;
          check_field("x_pulse", want.x_pulse, seen.x_pulse);
          check_field("z_pulse", want.z_pulse, seen.z_pulse);
          check_field("x_dir", want.x_dir, seen.x_dir);
          check_field("z_dir", want.z_dir, seen.z_dir);
          check_field("busy_res", want.busy, seen.busy);
          check_field("move_done", want.move_done, seen.move_done);
          check_field("rejected", want.rejected, seen.rejected);
        end
      end
      if (in_valid && !in_stall) begin
        want = apply_request(req_type, target_x, target_z, ms_tick);
        expected_status.push_back(want);
        if (want.move_done) done_count++;
        if (want.rejected) reject_count++;
      end
    end
    status_backlog = expected_status.size();
    motion_armed = axes_moving();
  end

endmodule

@@ tb/two_axis_stepper_ramp_generator_test.sv @@
// Top of the stepper ramp generator testbench: clock, reset, register setup,
// directed and random move requests, receiver stalls and the final verdict.
// Depends on tsrg_pkg, the block itself and stepper_ramp_checker.
`timescale 1ns / 100ps
module two_axis_stepper_ramp_generator_test;
  import tsrg_pkg::*;

  localparam int POS_W = POS_BITS_DEF;
  localparam int CYCLE_LIMIT = 800000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic              clk, rst;
  logic              in_valid, in_stall;
  logic [1:0]        req_type;
  logic [POS_W-1:0]  target_x, target_z;
  logic              ms_tick;
  logic              out_valid, out_stall;
  logic              x_pulse, z_pulse, x_dir, z_dir, busy_res, move_done, rejected;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  bit motion_armed;
  int status_backlog, error_count, checked_count, done_count, reject_count;

  // Stimulus bookkeeping.
  logic [POS_W-1:0] pos_x, pos_z;
  int total_requests, work_requests, setting_count, cycles;
  int x_reach, z_reach;
  bit no_gaps, ms_dense;

  two_axis_stepper_ramp_generator u_dut (.*);
  stepper_ramp_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver stalls: short bursts mostly, an occasional long one, and some
  // stretches where results flow freely.
  initial begin : result_backpressure
    int run;
    int hold;
    out_stall = 1'b0;
    forever begin
      if ($urandom_range(0, 7) == 0) begin
        run = $urandom_range(20, 80);
        hold = 0;
      end else begin
        run = $urandom_range(1, 6);
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      @(negedge clk) out_stall <= 1'b0;
      repeat (run - 1) @(negedge clk);
      if (hold > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
    end
  end

  // Present one request, with a random gap ahead of it, and hold it until taken.
  // The tracked position follows only requests that the block will act on.
  task automatic send_request(input logic [1:0] kind, input logic [POS_W-1:0] tx, tz,
                              input logic ms);
    int gap;
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 9))
        0, 1, 2:    gap = $urandom_range(1, 3);
        3:          gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : 1;
        default:    gap = 0;
      endcase
    end
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    total_requests++;
    if (motion_armed || kind == REQ_MOVE || kind == REQ_HOME) work_requests++;
    if (!motion_armed && kind == REQ_MOVE) begin
      pos_x = tx;
      pos_z = tz;
    end else if (!motion_armed && kind == REQ_HOME) begin
      pos_x = '0;
      pos_z = '0;
    end
    in_valid <= 1'b1;
    req_type <= kind;
    target_x <= tx;
    target_z <= tz;
    ms_tick <= ms;
    do @(posedge clk); while (in_stall);
    // Let the checker take in the accepted request before the caller looks at
    // the predicted motion state.
    #1;
  endtask

  // A target a bounded number of steps away, in either direction.
  function automatic logic [POS_W-1:0] pick_target(input logic [POS_W-1:0] origin,
                                                   input int reach);
    int d;
    if (reach == 0 || $urandom_range(0, 5) == 0) d = 0;
    else d = $urandom_range(1, reach);
    if (origin >= POS_W'(d) && $urandom_range(0, 1) == 1) return origin - POS_W'(d);
    return origin + POS_W'(d);
  endfunction

  // Longest move that keeps an axis within a few hundred ticks.
  function automatic int reach_of(input logic [PERIOD_W-1:0] start_p, fast_p);
    int slowest;
    slowest = (start_p > fast_p) ? int'(start_p) : int'(fast_p);
    return (slowest > 100) ? 0 : 100 / (slowest + 1);
  endfunction

  function automatic cfg_t settings(input int xs, xf, zs, zf, xse, zse, zcm);
    cfg_t c;
    c.x_start_period = PERIOD_W'(xs);
    c.x_fast_period  = PERIOD_W'(xf);
    c.z_start_period = PERIOD_W'(zs);
    c.z_fast_period  = PERIOD_W'(zf);
    c.x_slow_edges   = SLOW_W'(xse);
    c.z_slow_edges   = SLOW_W'(zse);
    c.z_change_ms    = TIMER_W'(zcm);
    return c;
  endfunction

  // Any request code with random fields; an idle move stays within reach.
  task automatic send_noise();
    logic [1:0] kind;
    kind = 2'($urandom_range(0, 3));
    if (!motion_armed && kind == REQ_MOVE) begin
      send_request(kind, pick_target(pos_x, x_reach), pick_target(pos_z, z_reach),
                   1'($urandom));
    end else begin
      send_request(kind, POS_W'($urandom), POS_W'($urandom), 1'($urandom));
    end
  endtask

  // Ticks with random fields, some noise if asked, until both axes are done.
  task automatic run_out_move(input bit with_noise);
    while (motion_armed) begin
      if (with_noise && $urandom_range(0, 29) == 0) begin
        send_noise();
      end else begin
        send_request(REQ_TICK, POS_W'($urandom), POS_W'($urandom),
                     ms_dense ? 1'b1 : ($urandom_range(0, 3) != 0));
      end
    end
  endtask

  task automatic wait_drained();
    while (status_backlog != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Registers change only once every result of the previous setting is back.
  task automatic apply_settings(input cfg_t c);
    @(negedge clk) in_valid <= 1'b0;
    wait_drained();
    write_register(CFG_X_START_PERIOD, DATA_W'(c.x_start_period));
    write_register(CFG_X_FAST_PERIOD, DATA_W'(c.x_fast_period));
    write_register(CFG_Z_START_PERIOD, DATA_W'(c.z_start_period));
    write_register(CFG_Z_FAST_PERIOD, DATA_W'(c.z_fast_period));
    write_register(CFG_X_SLOW_EDGES, DATA_W'(c.x_slow_edges));
    write_register(CFG_Z_SLOW_EDGES, DATA_W'(c.z_slow_edges));
    write_register(CFG_Z_CHANGE_MS, DATA_W'(c.z_change_ms));
    x_reach = reach_of(c.x_start_period, c.x_fast_period);
    z_reach = reach_of(c.z_start_period, c.z_fast_period);
    setting_count++;
  endtask

  // Mostly complete moves with random content, some loose noise in between.
  task automatic run_phase(input cfg_t c, input int budget);
    int goal;
    apply_settings(c);
    no_gaps = ($urandom_range(0, 3) == 0);
    ms_dense = ($urandom_range(0, 1) == 1);
    goal = work_requests + budget;
    while (work_requests < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) send_noise();
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          send_request(REQ_HOME, POS_W'($urandom), POS_W'($urandom), 1'($urandom));
        end
        send_request(REQ_MOVE, pick_target(pos_x, x_reach), pick_target(pos_z, z_reach),
                     1'($urandom));
        run_out_move(1'b1);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_TICK;
    target_x = '0;
    target_z = '0;
    ms_tick = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pos_x = '0;
    pos_z = '0;
    no_gaps = 1'b0;
    ms_dense = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: with zero periods every tick emits an edge, so moves are short.
    apply_settings(settings(0, 0, 0, 0, 0, 0, 0));
    send_request(REQ_TICK, '1, '1, 1'b1);       // idle tick changes nothing
    send_request(REQ_UNUSED, '0, '0, 1'b0);     // unknown request code
    send_request(REQ_HOME, '0, '0, 1'b0);
    send_request(REQ_MOVE, '0, '0, 1'b1);       // no distance: never busy
    send_request(REQ_MOVE, 2, 1, 1'b1);         // both axes up
    send_request(REQ_MOVE, '1, '1, 1'b1);       // rejected while busy
    send_request(REQ_HOME, '1, '0, 1'b0);       // rejected while busy
    send_request(REQ_UNUSED, '1, '1, 1'b1);
    run_out_move(1'b0);
    send_request(REQ_MOVE, 1, 1, 1'b0);         // X down, Z stays
    run_out_move(1'b0);
    send_request(REQ_MOVE, 1, 3, 1'b0);         // X stays, Z up
    run_out_move(1'b0);
    send_request(REQ_HOME, '0, '1, 1'b1);
    send_request(REQ_TICK, '0, '0, 1'b0);

    // Random phases over a range of register settings.
    run_phase(settings(0, 0, 0, 0, 0, 0, 0), 180);
    run_phase(settings(6, 1, 5, 2, 12, 10, 1), 200);
    run_phase(settings(2, 7, 3, 8, 4, 5, 3), 200);
    run_phase(settings(65535, 65535, 3, 0, 2097151, 2097151, 65535), 200);
    run_phase(settings(8, 0, 65535, 65534, 1, 7, 0), 200);
    repeat (3) begin
      run_phase(settings($urandom_range(0, 9), $urandom_range(0, 9), $urandom_range(0, 9),
                         $urandom_range(0, 9), $urandom_range(0, 40), $urandom_range(0, 40),
                         $urandom_range(0, 4)), 200);
    end
    run_phase(settings(40, 10, 40, 10, 2000, 2000, 1), 60);

    @(negedge clk) in_valid <= 1'b0;
    wait_drained();
    $display("Sent %0d requests (%0d acting on the axes), checked %0d results.",
             total_requests, work_requests, checked_count);
    $display("Saw %0d completed moves and %0d rejected requests over %0d register settings.",
             done_count, reject_count, setting_count);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
